/* rtl/core/sva_pkg.sv */
package sva_pkg;

    // Default number of voice slots
    localparam int VOICES_DEF = 8;

    // Item field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 2;
    localparam int FSLOT_W   = 3;
    localparam int OUTCOME_W = 3;
    localparam int AGE_W     = 32;
    localparam int MASK_W    = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // Seed hash constants
    localparam logic [AGE_W-1:0] SEED_BASE = 32'ha511e9b3;
    localparam logic [AGE_W-1:0] SEED_MUL  = 32'h9e3779b9;

    // MIDI message types (upper nibble of status) and controller numbers
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CONTROL  = 4'hb;
    localparam logic [BYTE_W-1:0] CC_ALL_SOUND_OFF = 8'd120;
    localparam logic [BYTE_W-1:0] CC_ALL_NOTES_OFF = 8'd123;
    localparam logic [LEN_W-1:0]  LEN_FULL         = 2'd3;

    // Result kinds carried on the output tuser
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_IGNORED      = 3'd0,
        OUT_STARTED      = 3'd1,
        OUT_RELEASED     = 3'd2,
        OUT_ALL_RELEASED = 3'd3,
        OUT_FREED        = 3'd4
    } outcome_t;

    // Decoded operation of one input beat
    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_START,
        OP_RELEASE_NOTE,
        OP_RELEASE_ALL,
        OP_FREE
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the input beat, clear scan state
        logic scan_step;  // read the slot at the scan pointer, advance
        logic commit;     // update the table and load the output register
    } sva_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;         // operation of the captured beat
        logic scan_last;  // scan pointer sits on the last slot
        logic out_free;   // output register can take a result now
    } sva_status_t;

endpackage

/* rtl/core/synth_voice_allocator.sv */
// Polyphonic voice allocator with oldest-voice stealing. Each input beat is a
// MIDI channel message or a voice-finished report; each gives exactly one
// result beat. Note-on takes the first free slot, or steals the oldest one;
// note-off or zero-velocity note-on releases matching slots; controllers 120
// and 123 release all; a finished report frees its slot if it is releasing.
// A note beat (start or release by note) scans the slot table, reading one
// slot per cycle from the note and age memories; other beats skip the scan.
// No new beat is taken until the last one's result is loaded into the output
// register, but one is taken while that result still waits there.
module synth_voice_allocator #(
    parameter int VOICES = sva_pkg::VOICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // status_byte[7:0], data_one[15:8], data_two[23:16], msg_length[25:24],
    // finished_slot[28:26], zero[31:29]
    input  logic [sva_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot[2:0], stolen[3], voice_seed[35:4], voice_note[43:36],
    // voice_velocity[51:44], changed_mask[59:52], zero[63:60]
    output logic [sva_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // outcome
    output logic [sva_pkg::OUTCOME_W-1:0]   m_axis_tuser
);
    import sva_pkg::*;

    sva_cmd_t    cmd;
    sva_status_t status;

    sva_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    sva_datapath #(
        .VOICES (VOICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/core/sva_ctrl.sv */
module sva_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  sva_pkg::sva_status_t status,
    output sva_pkg::sva_cmd_t    cmd
);
    import sva_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Handshake and commands
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load      = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.commit    = (state_reg == ST_FINISH) && status.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (status.op == OP_START || status.op == OP_RELEASE_NOTE)
                    state_next = ST_SCAN;
                else
                    state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/core/sva_datapath.sv */
module sva_datapath #(
    parameter int VOICES = sva_pkg::VOICES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sva_pkg::sva_cmd_t                   cmd,
    output sva_pkg::sva_status_t                status,
    input  logic [sva_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sva_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [sva_pkg::OUTCOME_W-1:0]       m_axis_tuser
);
    import sva_pkg::*;

    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICES - 1);

    // Input beat fields
    logic [BYTE_W-1:0]  in_status;
    logic [BYTE_W-1:0]  in_d1;
    logic [BYTE_W-1:0]  in_d2;
    logic [LEN_W-1:0]   in_len;
    logic [FSLOT_W-1:0] in_fslot;
    op_t                in_op;

    assign in_status = s_axis_tdata[7:0];
    assign in_d1     = s_axis_tdata[15:8];
    assign in_d2     = s_axis_tdata[23:16];
    assign in_len    = s_axis_tdata[25:24];
    assign in_fslot  = s_axis_tdata[28:26];

    // Message decode
    always_comb
    begin
        priority if (s_axis_tuser)
            in_op = OP_FREE;
        else if (in_len != LEN_FULL)
            in_op = OP_IGNORE;
        else if (in_status[7:4] == MSG_NOTE_ON && in_d2 != '0)
            in_op = OP_START;
        else if (in_status[7:4] == MSG_NOTE_OFF || in_status[7:4] == MSG_NOTE_ON)
            in_op = OP_RELEASE_NOTE;
        else if (in_status[7:4] == MSG_CONTROL
                 && (in_d1 == CC_ALL_SOUND_OFF || in_d1 == CC_ALL_NOTES_OFF))
            in_op = OP_RELEASE_ALL;
        else
            in_op = OP_IGNORE;
    end

    // Captured beat
    op_t                op_reg;
    logic [BYTE_W-1:0]  d1_reg;
    logic [BYTE_W-1:0]  d2_reg;
    logic [FSLOT_W-1:0] fslot_reg;
    logic [AGE_W-1:0]   prod_reg;

    // Slot table: flags in flops, note and age in memories
    logic [VOICES-1:0]  active_reg;
    logic [VOICES-1:0]  releasing_reg;
    logic [BYTE_W-1:0]  note_mem [VOICES];
    logic [AGE_W-1:0]   age_mem  [VOICES];
    logic [AGE_W-1:0]   counter_reg;

    // Scan pointer and read stage
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic [SLOT_W-1:0]  rd_idx_reg;
    logic               rd_valid_reg;
    logic [BYTE_W-1:0]  note_rd_reg;
    logic [AGE_W-1:0]   age_rd_reg;

    // Scan results
    logic               found_free_reg;
    logic [SLOT_W-1:0]  free_idx_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    logic [AGE_W-1:0]   best_age_reg;
    logic [MASK_W-1:0]  rel_mask_reg;

    // Output register
    logic               out_valid_reg;
    outcome_t           out_outcome_reg;
    logic [FSLOT_W-1:0] out_slot_reg;
    logic               out_stolen_reg;
    logic [AGE_W-1:0]   out_seed_reg;
    logic [BYTE_W-1:0]  out_note_reg;
    logic [BYTE_W-1:0]  out_vel_reg;
    logic [MASK_W-1:0]  out_mask_reg;

    // Result of the beat being committed
    outcome_t           out_outcome_next;
    logic [FSLOT_W-1:0] out_slot_next;
    logic               out_stolen_next;
    logic [AGE_W-1:0]   out_seed_next;
    logic [BYTE_W-1:0]  out_note_next;
    logic [BYTE_W-1:0]  out_vel_next;
    logic [MASK_W-1:0]  out_mask_next;

    // Commit helpers
    logic [SLOT_W-1:0]  sel_idx;
    logic [AGE_W-1:0]   counter_next;
    logic [SLOT_W-1:0]  fslot_idx;
    logic               fslot_ok;
    logic [VOICES+MASK_W-1:0] all_rel_ext;

    assign sel_idx      = found_free_reg ? free_idx_reg : best_idx_reg;
    assign counter_next = counter_reg + 1'b1;
    assign fslot_idx    = SLOT_W'(fslot_reg);
    assign fslot_ok     = (32'(fslot_reg) < VOICES)
                          && active_reg[fslot_idx] && releasing_reg[fslot_idx];
    assign all_rel_ext  = {{MASK_W{1'b0}}, active_reg & ~releasing_reg};

    // Status
    always_comb
    begin
        status.op        = op_reg;
        status.scan_last = (scan_idx_reg == LAST_SLOT);
        status.out_free  = !out_valid_reg || m_axis_tready;
    end

    // Beat capture and seed product (8 x 32 bits, settles before commit)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d1_reg    <= in_d1;
            d2_reg    <= in_d2;
            fslot_reg <= in_fslot;
        end
        prod_reg <= AGE_W'(d1_reg * SEED_MUL);
    end

    // Note and age memories: one read port for the scan, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            note_rd_reg <= note_mem[scan_idx_reg];
            age_rd_reg  <= age_mem[scan_idx_reg];
        end
        if (cmd.commit && op_reg == OP_START)
        begin
            note_mem[sel_idx] <= d1_reg;
            age_mem[sel_idx]  <= counter_next;
        end
    end

    // Control state, slot flags and scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_IGNORE;
            active_reg     <= '0;
            releasing_reg  <= '0;
            counter_reg    <= '0;
            scan_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            found_free_reg <= 1'b0;
            free_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_age_reg   <= '0;
            rel_mask_reg   <= '0;
        end
        else
        begin
            // new beat: restart the scan
            if (cmd.load)
            begin
                op_reg         <= in_op;
                scan_idx_reg   <= '0;
                found_free_reg <= 1'b0;
                rel_mask_reg   <= '0;
            end

            // issue one slot read per step
            rd_valid_reg <= cmd.scan_step;
            if (cmd.scan_step)
            begin
                rd_idx_reg   <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            // evaluate the slot whose data has arrived
            if (rd_valid_reg)
            begin
                if (op_reg == OP_START)
                begin
                    if (!active_reg[rd_idx_reg] && !found_free_reg)
                    begin
                        found_free_reg <= 1'b1;
                        free_idx_reg   <= rd_idx_reg;
                    end
                    // oldest voice, first slot on ties
                    if (rd_idx_reg == '0 || age_rd_reg < best_age_reg)
                    begin
                        best_age_reg <= age_rd_reg;
                        best_idx_reg <= rd_idx_reg;
                    end
                end
                else if (op_reg == OP_RELEASE_NOTE)
                begin
                    if (active_reg[rd_idx_reg] && note_rd_reg == d1_reg)
                    begin
                        releasing_reg[rd_idx_reg] <= 1'b1;
                        if (!releasing_reg[rd_idx_reg] && 32'(rd_idx_reg) < MASK_W)
                            rel_mask_reg[3'(rd_idx_reg)] <= 1'b1;
                    end
                end
            end

            // table update at commit
            if (cmd.commit)
            begin
                unique case (op_reg)
                    OP_START:
                    begin
                        counter_reg            <= counter_next;
                        active_reg[sel_idx]    <= 1'b1;
                        releasing_reg[sel_idx] <= 1'b0;
                    end
                    OP_RELEASE_ALL:
                    begin
                        releasing_reg <= releasing_reg | active_reg;
                    end
                    OP_FREE:
                    begin
                        if (fslot_ok)
                        begin
                            active_reg[fslot_idx]    <= 1'b0;
                            releasing_reg[fslot_idx] <= 1'b0;
                        end
                    end
                    OP_IGNORE, OP_RELEASE_NOTE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result fields for the committed beat
    always_comb
    begin
        out_outcome_next = OUT_IGNORED;
        out_slot_next    = '0;
        out_stolen_next  = 1'b0;
        out_seed_next    = '0;
        out_note_next    = '0;
        out_vel_next     = '0;
        out_mask_next    = '0;
        unique case (op_reg)
            OP_START:
            begin
                out_outcome_next = OUT_STARTED;
                out_slot_next    = 3'(sel_idx);
                out_stolen_next  = !found_free_reg;
                out_seed_next    = SEED_BASE ^ prod_reg ^ counter_next;
                out_note_next    = d1_reg;
                out_vel_next     = d2_reg;
            end
            OP_RELEASE_NOTE:
            begin
                out_outcome_next = OUT_RELEASED;
                out_mask_next    = rel_mask_reg;
            end
            OP_RELEASE_ALL:
            begin
                out_outcome_next = OUT_ALL_RELEASED;
                out_mask_next    = all_rel_ext[MASK_W-1:0];
            end
            OP_FREE:
            begin
                if (fslot_ok)
                begin
                    out_outcome_next = OUT_FREED;
                    out_slot_next    = fslot_reg;
                end
            end
            OP_IGNORE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_outcome_reg <= out_outcome_next;
            out_slot_reg    <= out_slot_next;
            out_stolen_reg  <= out_stolen_next;
            out_seed_reg    <= out_seed_next;
            out_note_reg    <= out_note_next;
            out_vel_reg     <= out_vel_next;
            out_mask_reg    <= out_mask_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_outcome_reg;
    assign m_axis_tdata  = {4'b0000, out_mask_reg, out_vel_reg, out_note_reg,
                            out_seed_reg, out_stolen_reg, out_slot_reg};

endmodule

/* verif/voice_alloc_checker.sv */
// Watches both stream channels of the voice allocator, predicts one result
// per accepted input beat from its own copy of the slot table, and compares
// each accepted result beat field by field with the oldest prediction.
module voice_alloc_checker
    import sva_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic [OUTCOME_W-1:0]   m_axis_tuser,
    output int                     fail_count,
    output int                     results_waiting,
    output int                     n_started,
    output int                     n_stolen,
    output int                     n_note_rel,
    output int                     n_all_rel,
    output int                     n_freed,
    output int                     n_ignored
);

    localparam int NV = VOICES_DEF;

    typedef struct packed {
        outcome_t          outcome;
        logic [2:0]        slot;
        logic              stolen;
        logic [AGE_W-1:0]  seed;
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] velocity;
        logic [MASK_W-1:0] mask;
    } voice_result_t;

    // predicted slot table
    logic              tbl_active    [NV];
    logic              tbl_releasing [NV];
    logic [BYTE_W-1:0] tbl_note      [NV];
    logic [AGE_W-1:0]  tbl_age       [NV];
    logic [AGE_W-1:0]  starts_issued;

    voice_result_t pending_results[$];

    int errors;
    int beats_seen;
    int cnt_start, cnt_steal, cnt_note_rel, cnt_all_rel, cnt_free, cnt_ign;

    task automatic report_mismatch(input string what, input logic [AGE_W-1:0] got,
                                   input logic [AGE_W-1:0] want);
        $display("result beat %0d: %s got 0x%0h, want 0x%0h", beats_seen, what, got, want);
        errors++;
    endtask

    // move active slots (matching the note when by_note) to release; returns changed slots
    function automatic logic [MASK_W-1:0] release_matching(input logic by_note,
                                                           input logic [BYTE_W-1:0] note);
        logic [MASK_W-1:0] changed;
        changed = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (tbl_active[i] && (!by_note || tbl_note[i] == note))
            begin
                if (!tbl_releasing[i] && i < MASK_W)
                    changed[i] = 1'b1;
                tbl_releasing[i] = 1'b1;
            end
        end
        return changed;
    endfunction

    // work out the result of one input beat and update the table
    task automatic apply_voice_event(input logic act, input logic [IN_DATA_W-1:0] beat,
                                     output voice_result_t res);
        logic [BYTE_W-1:0]  status;
        logic [BYTE_W-1:0]  d1;
        logic [BYTE_W-1:0]  d2;
        logic [LEN_W-1:0]   len;
        logic [FSLOT_W-1:0] fs;
        int                 sel;
        logic               took;
        status = beat[7:0];
        d1     = beat[15:8];
        d2     = beat[23:16];
        len    = beat[25:24];
        fs     = beat[28:26];
        res = '0;
        res.outcome = OUT_IGNORED;
        if (act)
        begin
            if (int'(fs) < NV && tbl_active[fs] && tbl_releasing[fs])
            begin
                tbl_active[fs]    = 1'b0;
                tbl_releasing[fs] = 1'b0;
                tbl_note[fs]      = '0;
                tbl_age[fs]       = '0;
                res.outcome = OUT_FREED;
                res.slot    = fs;
            end
        end
        else if (len == LEN_FULL)
        begin
            if (status[7:4] == MSG_NOTE_ON && d2 != '0)
            begin
                sel  = -1;
                took = 1'b0;
                for (int k = 0; k < NV; k++)
                begin
                    if (sel < 0 && !tbl_active[k])
                        sel = k;
                end
                // table full: steal the lowest age, first slot on ties
                if (sel < 0)
                begin
                    took = 1'b1;
                    sel  = 0;
                    for (int k = 1; k < NV; k++)
                    begin
                        if (tbl_age[k] < tbl_age[sel])
                            sel = k;
                    end
                end
                starts_issued      = starts_issued + 1'b1;
                tbl_active[sel]    = 1'b1;
                tbl_releasing[sel] = 1'b0;
                tbl_note[sel]      = d1;
                tbl_age[sel]       = starts_issued;
                res.outcome  = OUT_STARTED;
                res.slot     = sel[2:0];
                res.stolen   = took;
                res.seed     = SEED_BASE ^ (AGE_W'(d1) * SEED_MUL) ^ starts_issued;
                res.note     = d1;
                res.velocity = d2;
            end
            else if (status[7:4] == MSG_NOTE_OFF || status[7:4] == MSG_NOTE_ON)
            begin
                res.outcome = OUT_RELEASED;
                res.mask    = release_matching(1'b1, d1);
            end
            else if (status[7:4] == MSG_CONTROL &&
                     (d1 == CC_ALL_SOUND_OFF || d1 == CC_ALL_NOTES_OFF))
            begin
                res.outcome = OUT_ALL_RELEASED;
                res.mask    = release_matching(1'b0, '0);
            end
        end
    endtask

    // result side first, then the input side of the same edge
    always @(posedge clk)
    begin : watch
        voice_result_t got;
        voice_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                tbl_active[i]    = 1'b0;
                tbl_releasing[i] = 1'b0;
                tbl_note[i]      = '0;
                tbl_age[i]       = '0;
            end
            starts_issued = '0;
            pending_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.outcome  = outcome_t'(m_axis_tuser);
                got.slot     = m_axis_tdata[2:0];
                got.stolen   = m_axis_tdata[3];
                got.seed     = m_axis_tdata[35:4];
                got.note     = m_axis_tdata[43:36];
                got.velocity = m_axis_tdata[51:44];
                got.mask     = m_axis_tdata[59:52];
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat, outcome", AGE_W'(got.outcome), '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.outcome !== want.outcome)
                        report_mismatch("outcome", AGE_W'(got.outcome), AGE_W'(want.outcome));
                    if (got.slot !== want.slot)
                        report_mismatch("slot", AGE_W'(got.slot), AGE_W'(want.slot));
                    if (got.stolen !== want.stolen)
                        report_mismatch("stolen", AGE_W'(got.stolen), AGE_W'(want.stolen));
                    if (got.seed !== want.seed)
                        report_mismatch("voice_seed", got.seed, want.seed);
                    if (got.note !== want.note)
                        report_mismatch("voice_note", AGE_W'(got.note), AGE_W'(want.note));
                    if (got.velocity !== want.velocity)
                        report_mismatch("voice_velocity", AGE_W'(got.velocity),
                                        AGE_W'(want.velocity));
                    if (got.mask !== want.mask)
                        report_mismatch("changed_mask", AGE_W'(got.mask), AGE_W'(want.mask));
                end
                beats_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_voice_event(s_axis_tuser, s_axis_tdata, want);
                pending_results.push_back(want);
                case (want.outcome)
                    OUT_STARTED:
                    begin
                        cnt_start++;
                        if (want.stolen)
                            cnt_steal++;
                    end
                    OUT_RELEASED:     cnt_note_rel++;
                    OUT_ALL_RELEASED: cnt_all_rel++;
                    OUT_FREED:        cnt_free++;
                    default:          cnt_ign++;
                endcase
            end
        end
        fail_count      <= errors;
        results_waiting <= pending_results.size();
        n_started       <= cnt_start;
        n_stolen        <= cnt_steal;
        n_note_rel      <= cnt_note_rel;
        n_all_rel       <= cnt_all_rel;
        n_freed         <= cnt_free;
        n_ignored       <= cnt_ign;
    end

endmodule

/* verif/tb.sv */
module tb;
    import sva_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_EVENTS = 1350;
    localparam int DRAIN_CYCLES = 4 * VOICES_DEF + 16;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // status_byte, data_one, data_two, msg_length, finished_slot, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // action
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // slot, stolen, voice_seed, voice_note, voice_velocity, changed_mask, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // outcome
    logic [OUTCOME_W-1:0]  m_axis_tuser;

    int fail_count, results_waiting;
    int n_started, n_stolen, n_note_rel, n_all_rel, n_freed, n_ignored;

    int cycle_count = 0;
    int beats_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    synth_voice_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    voice_alloc_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .n_started       (n_started),
        .n_stolen        (n_stolen),
        .n_note_rel      (n_note_rel),
        .n_all_rel       (n_all_rel),
        .n_freed         (n_freed),
        .n_ignored       (n_ignored)
    );

    // clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("synth_voice_allocator verification failed");
        $finish;
    end

    // receiver: free-running, coin-toss or heavily stalled, in stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [IN_DATA_W-1:0] midi_beat(input logic [7:0] status,
                                                       input logic [7:0] d1,
                                                       input logic [7:0] d2,
                                                       input logic [1:0] len,
                                                       input logic [2:0] fslot);
        return {3'b000, fslot, len, d2, d1, status};
    endfunction

    // drive one beat, wait for its handshake, then maybe open a gap
    task automatic send_event(input logic act, input logic [IN_DATA_W-1:0] beat);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [7:0] pick_note();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(60, 71));
    endfunction

    initial
    begin : stimulus
        int useful;
        int kind;
        logic [3:0] chan;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: starts at the data extremes into slots 0..2
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h0}, 8'd0, 8'd127, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'hf}, 8'd127, 8'd1, LEN_FULL, 3'd7));
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h5}, 8'd255, 8'd255, LEN_FULL, 3'd5));
        // short messages
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h0}, 8'd60, 8'd64, 2'd0, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h0}, 8'd60, 8'd64, 2'd1, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h0}, 8'd60, 8'd64, 2'd2, 3'd0));
        // note-on with zero velocity, note-off, no match, already releasing
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h0}, 8'd0, 8'd0, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_OFF, 4'h3}, 8'd127, 8'd64, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_OFF, 4'h0}, 8'd99, 8'd0, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_OFF, 4'h0}, 8'd127, 8'd0, LEN_FULL, 3'd0));
        // finished: releasing slot, then idle slot, then slot 7 idle
        send_event(1'b1, midi_beat(8'h00, 8'h00, 8'h00, 2'd0, 3'd0));
        send_event(1'b1, midi_beat(8'hff, 8'hff, 8'hff, LEN_FULL, 3'd0));
        send_event(1'b1, midi_beat(8'h00, 8'h00, 8'h00, 2'd0, 3'd7));
        // other controllers and message types
        send_event(1'b0, midi_beat({MSG_CONTROL, 4'h0}, 8'd121, 8'd0, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat(8'hc0, 8'd5, 8'd0, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat(8'hff, 8'hff, 8'hff, LEN_FULL, 3'd7));
        // fill the table, then steal the oldest
        for (int n = 10; n < 16; n++)
            send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h2}, n[7:0], 8'd90, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat({MSG_NOTE_ON, 4'h2}, 8'd20, 8'd100, LEN_FULL, 3'd0));
        // release all, twice
        send_event(1'b0, midi_beat({MSG_CONTROL, 4'h1}, CC_ALL_NOTES_OFF, 8'd0, LEN_FULL, 3'd0));
        send_event(1'b0, midi_beat({MSG_CONTROL, 4'h0}, CC_ALL_SOUND_OFF, 8'd0, LEN_FULL, 3'd0));
        send_event(1'b1, midi_beat(8'h00, 8'h00, 8'h00, 2'd0, 3'd7));

        // random: mostly well-formed traffic, some noise
        useful = 0;
        while (useful < RANDOM_EVENTS)
        begin
            kind = $urandom_range(0, 99);
            chan = 4'($urandom_range(0, 15));
            if (kind < 40)
            begin
                send_event(1'b0, midi_beat({MSG_NOTE_ON, chan}, pick_note(),
                                           8'($urandom_range(1, 255)), LEN_FULL,
                                           3'($urandom_range(0, 7))));
                useful++;
            end
            else if (kind < 62)
            begin
                if ($urandom_range(0, 1))
                    send_event(1'b0, midi_beat({MSG_NOTE_OFF, chan}, pick_note(),
                                               8'($urandom_range(0, 255)), LEN_FULL,
                                               3'($urandom_range(0, 7))));
                else
                    send_event(1'b0, midi_beat({MSG_NOTE_ON, chan}, pick_note(), 8'd0,
                                               LEN_FULL, 3'($urandom_range(0, 7))));
                useful++;
            end
            else if (kind < 80)
            begin
                send_event(1'b1, midi_beat(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           2'($urandom_range(0, 3)),
                                           3'($urandom_range(0, 7))));
                useful++;
            end
            else if (kind < 85)
            begin
                send_event(1'b0, midi_beat({MSG_CONTROL, chan},
                                           $urandom_range(0, 1) ? CC_ALL_SOUND_OFF
                                                                : CC_ALL_NOTES_OFF,
                                           8'($urandom_range(0, 255)), LEN_FULL,
                                           3'($urandom_range(0, 7))));
                useful++;
            end
            else
            begin
                send_event(1'b0, midi_beat(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           2'($urandom_range(0, 3)),
                                           3'($urandom_range(0, 7))));
                useful++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (results_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d events: %0d starts with %0d steals, %0d note releases, %0d release-all",
                 beats_sent, n_started, n_stolen, n_note_rel, n_all_rel);
        $display("%0d slots freed, %0d events ignored, %0d mismatches",
                 n_freed, n_ignored, fail_count);
        if (fail_count == 0)
            $display("synth_voice_allocator verification clean");
        else
            $display("synth_voice_allocator verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sva_pkg.sv
rtl/core/sva_ctrl.sv
rtl/core/sva_datapath.sv
rtl/core/synth_voice_allocator.sv
verif/voice_alloc_checker.sv
verif/tb.sv
